FILE: rtl/breakpoint_comparator_slots_assert.svh
// Assertion macros for the breakpoint comparator slot block.
// Depends on nothing; included by the top level.
`ifndef BREAKPOINT_COMPARATOR_SLOTS_ASSERT_SVH
`define BREAKPOINT_COMPARATOR_SLOTS_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define BCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcs assertion failed");

// Next-cycle implication, reset disables the check.
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcs assertion failed");

`endif

FILE: rtl/bcs_pkg.sv
// Package for the breakpoint comparator slot block: constants, types and
// the comparator word encoder. Depends on nothing.
package bcs_pkg;

	localparam int NUM_SLOTS = 6;
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam logic [31:0] ADDR_MASK    = 32'h0fff_fffc;
	localparam logic [31:0] HALF_SEL_BIT = 32'h0000_0002;
	localparam logic [31:0] ENABLE_BIT   = 32'h0000_0001;
	localparam logic [31:0] REPL_LOW     = 32'h4000_0000;
	localparam logic [31:0] REPL_HIGH    = 32'h8000_0000;
	localparam logic [31:0] REPL_WORD    = 32'hc000_0000;

	localparam logic [2:0] SIZE_DEFAULT = 3'd0;
	localparam logic [2:0] SIZE_HALF    = 3'd2;

	typedef enum logic [1:0] {
		CMD_SET       = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_DISABLE   = 2'd2,
		CMD_CLEAR_ALL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	function automatic logic [31:0] encode_word(input logic [31:0] addr,
			input logic [2:0] size);
		logic [31:0] repl;
		if (size == SIZE_DEFAULT || size == SIZE_HALF) begin
			repl = ((addr & HALF_SEL_BIT) != '0) ? REPL_HIGH : REPL_LOW;
		end else begin
			repl = REPL_WORD;
		end
		return repl | (addr & ADDR_MASK) | ENABLE_BIT;
	endfunction

endpackage

FILE: rtl/bcs_if.sv
// Valid/ready channel interfaces for command and result beats.
// Depends on nothing.
interface bcs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] address;
	logic [2:0]  access_size;

	modport source (output valid, command, address, access_size, input ready);
	modport sink (input valid, command, address, access_size, output ready);
endinterface

interface bcs_rsp_if;
	logic        valid;
	logic        ready;
	logic        success;
	logic [2:0]  slot_index;
	logic [31:0] comparator_word;

	modport source (output valid, success, slot_index, comparator_word, input ready);
	modport sink (input valid, success, slot_index, comparator_word, output ready);
endinterface

FILE: rtl/breakpoint_comparator_slots.sv
// Breakpoint comparator slot table: set, clear, disable and clear-all commands.
// Depends on bcs_pkg, bcs_if.sv and breakpoint_comparator_slots_assert.svh.
// A result beat follows its command beat once the slot scan finishes (clear-all skips the scan);
// the slot memory is read one entry per cycle until a hit or the last slot.
// One command at a time: a new command is taken only after its result is loaded into the output register.
// Reset: all slots read as zero, the block is idle and no result is pending.
`include "breakpoint_comparator_slots_assert.svh"

module breakpoint_comparator_slots (
	input  logic      clk,
	input  logic      arst_n,
	bcs_cmd_if.sink   req,
	bcs_rsp_if.source rsp
);

	logic [31:0] slot_mem [bcs_pkg::NUM_SLOTS];
	logic [bcs_pkg::NUM_SLOTS-1:0] valid_q;

	bcs_pkg::state_t state_q, state_d;
	bcs_pkg::cmd_t   cmd_q;
	logic [31:0]     addr_q;
	logic [31:0]     word_q;
	logic [bcs_pkg::CNT_W-1:0] rd_idx_q;

	logic                      live_s1;
	logic [bcs_pkg::IDX_W-1:0] idx_s1;
	logic [31:0]               rd_data_s1;
	logic                      ent_vld_s1;

	logic        res_ok_q;
	logic [2:0]  res_idx_q;
	logic [31:0] res_word_q;

	logic        out_vld_q;
	logic        out_ok_q;
	logic [2:0]  out_idx_q;
	logic [31:0] out_word_q;

	logic        accept;
	logic        issue;
	logic        hit;
	logic        finish;
	logic        wr_en;
	logic        new_valid;
	logic        load_out;
	logic [31:0] entry;
	logic [31:0] new_word;
	logic [31:0] res_word;
	logic [31:0] idx_wide;

	assign req.ready = (state_q == bcs_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign issue     = (state_q == bcs_pkg::ST_SCAN) &&
		(rd_idx_q != bcs_pkg::CNT_W'(bcs_pkg::NUM_SLOTS));
	assign entry     = ent_vld_s1 ? rd_data_s1 : '0;
	assign idx_wide  = 32'(idx_s1);

	always_comb begin
		hit       = 1'b0;
		new_word  = '0;
		res_word  = '0;
		new_valid = 1'b0;
		case (cmd_q)
			bcs_pkg::CMD_SET: begin
				hit       = (entry & bcs_pkg::ENABLE_BIT) == '0;
				new_word  = word_q;
				res_word  = word_q;
				new_valid = 1'b1;
			end
			bcs_pkg::CMD_CLEAR: begin
				hit       = (entry | bcs_pkg::ENABLE_BIT) == word_q;
				new_word  = '0;
				res_word  = '0;
				new_valid = 1'b0;
			end
			bcs_pkg::CMD_DISABLE: begin
				hit       = (entry & bcs_pkg::ADDR_MASK) == (addr_q & bcs_pkg::ADDR_MASK);
				new_word  = entry & ~bcs_pkg::ENABLE_BIT;
				res_word  = entry & ~bcs_pkg::ENABLE_BIT;
				new_valid = 1'b1;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		finish   = (state_q == bcs_pkg::ST_SCAN) && live_s1 &&
			(hit || idx_s1 == bcs_pkg::IDX_W'(bcs_pkg::NUM_SLOTS - 1));
		wr_en    = finish && hit;
		load_out = (state_q == bcs_pkg::ST_DONE) && (!out_vld_q || rsp.ready);
		case (state_q)
			bcs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (bcs_pkg::cmd_t'(req.command) == bcs_pkg::CMD_CLEAR_ALL) ?
						bcs_pkg::ST_DONE : bcs_pkg::ST_SCAN;
				end
			end
			bcs_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = bcs_pkg::ST_DONE;
				end
			end
			bcs_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = bcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[idx_s1] <= new_word;
		end
		rd_data_s1 <= slot_mem[rd_idx_q[bcs_pkg::IDX_W-1:0]];
		idx_s1     <= rd_idx_q[bcs_pkg::IDX_W-1:0];
		if (accept) begin
			cmd_q  <= bcs_pkg::cmd_t'(req.command);
			addr_q <= req.address;
			word_q <= bcs_pkg::encode_word(req.address, req.access_size);
		end
		if (accept) begin
			res_ok_q   <= 1'b1;
			res_idx_q  <= '0;
			res_word_q <= '0;
		end else if (finish) begin
			res_ok_q   <= hit;
			res_idx_q  <= hit ? idx_wide[2:0] : 3'd0;
			res_word_q <= hit ? res_word : '0;
		end
		if (load_out) begin
			out_ok_q   <= res_ok_q;
			out_idx_q  <= res_idx_q;
			out_word_q <= res_word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_idx_q   <= '0;
			live_s1    <= 1'b0;
			ent_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept && bcs_pkg::cmd_t'(req.command) == bcs_pkg::CMD_CLEAR_ALL) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[idx_s1] <= new_valid;
			end
			if (accept) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			live_s1    <= issue;
			ent_vld_s1 <= valid_q[rd_idx_q[bcs_pkg::IDX_W-1:0]];
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.success         = out_ok_q;
	assign rsp.slot_index      = out_idx_q;
	assign rsp.comparator_word = out_word_q;

	`BCS_ASSERT_SAME(a_idle_no_compare, clk, arst_n, state_q == bcs_pkg::ST_IDLE, !live_s1)
	`BCS_ASSERT_SAME(a_write_in_scan, clk, arst_n, wr_en, state_q == bcs_pkg::ST_SCAN)
	`BCS_ASSERT_NEXT(a_clear_all_empties, clk, arst_n, accept && req.command == bcs_pkg::CMD_CLEAR_ALL, valid_q == '0)

endmodule
